// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define GOST_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define GOST_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/gost_pkg.sv
`timescale 1ns / 1ps
package gost_pkg;

    localparam int BLK_W      = 64;
    localparam int WORD_W     = 32;
    localparam int KEY_REGS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 64;
    localparam int ROUND_W    = 5;
    localparam int SBOX_DEPTH = 16;
    localparam int SBOX_AW    = 4;
    localparam int NIB_W      = 4;
    localparam int NUM_BOX    = 8;
    localparam int CNT_W      = 4;
    localparam int OP_W       = 3;
    localparam int KSEL_W     = 3;
    localparam int ROT_AMT    = 11;

    localparam logic [WORD_W-1:0]  CTR_ADD_LOW       = 32'h0101_0101;
    localparam logic [WORD_W-1:0]  CTR_ADD_HIGH      = 32'h0101_0104;
    localparam logic [ROUND_W-1:0] LAST_ROUND_CIPHER = 5'd31;
    localparam logic [ROUND_W-1:0] LAST_ROUND_MAC    = 5'd15;
    localparam logic [CNT_W-1:0]   FULL_BYTES        = 4'd8;
    localparam logic [KSEL_W-1:0]  KSEL_TOP          = 3'h7;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 3'd0,
        OP_ENC       = 3'd1,
        OP_DEC       = 3'd2,
        OP_CTR_START = 3'd3,
        OP_CTR_BLOCK = 3'd4,
        OP_MAC       = 3'd5
    } op_t;

    typedef struct packed {
        logic               capture;
        logic               prime;
        logic               step;
        logic               finish;
        logic [ROUND_W-1:0] rnd;
    } gost_cmd_t;

    typedef struct packed {
        logic quick;
        logic mac;
    } gost_stat_t;

    // Key word index for a round: forward order except the reversed passes.
    function automatic logic [KSEL_W-1:0] key_sel(input op_t op, input logic [ROUND_W-1:0] rnd);
        logic rev;
        begin
            if (op == OP_DEC)
                rev = (rnd[ROUND_W-1:KSEL_W] != '0);
            else
                rev = (rnd[ROUND_W-1:KSEL_W] == '1);
            key_sel = rev ? (KSEL_TOP - rnd[KSEL_W-1:0]) : rnd[KSEL_W-1:0];
        end
    endfunction

    // Keep the low bytes up to the count, saturated to a full block.
    function automatic logic [BLK_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] sat;
        logic [BLK_W-1:0] m;
        begin
            sat = (cnt > FULL_BYTES) ? FULL_BYTES : cnt;
            for (int i = 0; i < BLK_W / 8; i++)
            begin
                m[8*i +: 8] = {8{CNT_W'(i) < sat}};
            end
            byte_mask = m;
        end
    endfunction

    function automatic logic [WORD_W-1:0] rotl11(input logic [WORD_W-1:0] y);
        rotl11 = {y[WORD_W-ROT_AMT-1:0], y[WORD_W-1:WORD_W-ROT_AMT]};
    endfunction

endpackage

// File: design/gost_if.sv
`timescale 1ns / 1ps
interface gost_in_if;
    import gost_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SBOX_AW-1:0]  table_index;
    logic [WORD_W-1:0]   table_word;
    logic [BLK_W-1:0]    data_block;
    logic [CNT_W-1:0]    byte_count;
    logic                mac_restart;

    modport source (
        output valid, operation, table_index, table_word, data_block, byte_count,
               mac_restart,
        input  ready
    );
    modport sink (
        input  valid, operation, table_index, table_word, data_block, byte_count,
               mac_restart,
        output ready
    );
endinterface

interface gost_out_if;
    import gost_pkg::*;

    logic               valid;
    logic               ready;
    logic [BLK_W-1:0]   result_block;
    logic [WORD_W-1:0]  mac_word;

    modport source (
        output valid, result_block, mac_word,
        input  ready
    );
    modport sink (
        input  valid, result_block, mac_word,
        output ready
    );
endinterface

// File: design/gost_ram.sv
`timescale 1ns / 1ps
module gost_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: design/gost_ctrl.sv
`timescale 1ns / 1ps
module gost_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  gost_pkg::gost_stat_t stat,
    output gost_pkg::gost_cmd_t  cmd
);
    import gost_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PRIME  = 4'b0010,
        ST_ROUND  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic               is_mac_reg, is_mac_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               finish;
    logic [ROUND_W-1:0] last_round;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign last_round = is_mac_reg ? LAST_ROUND_MAC : LAST_ROUND_CIPHER;
    // Write the result only once the output register is free or draining.
    assign finish     = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next  = state_reg;
        rnd_next    = rnd_reg;
        is_mac_next = is_mac_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_mac_next = stat.mac;
                    state_next  = stat.quick ? ST_FINISH : ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == last_round)
                    state_next = ST_FINISH;
                else
                    rnd_next = rnd_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            is_mac_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            is_mac_reg    <= is_mac_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cmd.capture = accept;
    assign cmd.prime   = (state_reg == ST_PRIME);
    assign cmd.step    = (state_reg == ST_ROUND);
    assign cmd.finish  = finish;
    assign cmd.rnd     = rnd_reg;
endmodule

// File: design/gost_dpath.sv
`timescale 1ns / 1ps
module gost_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [gost_pkg::OP_W-1:0]       operation,
    input  logic [gost_pkg::SBOX_AW-1:0]    table_index,
    input  logic [gost_pkg::WORD_W-1:0]     table_word,
    input  logic [gost_pkg::BLK_W-1:0]      data_block,
    input  logic [gost_pkg::CNT_W-1:0]      byte_count,
    input  logic                            mac_restart,
    input  logic                            cfg_wr_en,
    input  logic [gost_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gost_pkg::CFG_W-1:0]      cfg_data,
    input  gost_pkg::gost_cmd_t             cmd,
    output gost_pkg::gost_stat_t            stat,
    output logic [gost_pkg::BLK_W-1:0]      result_block,
    output logic [gost_pkg::WORD_W-1:0]     mac_word
);
    import gost_pkg::*;

    logic [CFG_W-1:0]   key_reg [KEY_REGS];
    op_t                op_in;
    op_t                op_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [BLK_W-1:0]   data_reg;
    logic [WORD_W-1:0]  a_reg, b_reg;
    logic [WORD_W-1:0]  a_next, b_next;
    logic [BLK_W-1:0]   counter_reg, counter_next;
    logic [BLK_W-1:0]   mac_reg;
    logic [BLK_W-1:0]   mac_in;
    logic [BLK_W-1:0]   result_reg, result_next;
    logic [WORD_W-1:0]  mac_word_reg;
    logic [WORD_W-1:0]  ctr_lo;
    logic [WORD_W:0]    ctr_hi_sum;
    logic [WORD_W-1:0]  ctr_hi;
    logic [WORD_W-1:0]  sub_word;
    logic [WORD_W-1:0]  new_half;
    logic [KSEL_W-1:0]  ksel;
    logic [CFG_W-1:0]   kpair;
    logic [WORD_W-1:0]  key_word;
    logic [WORD_W-1:0]  addr_word;
    logic               table_we;

    assign op_in = op_t'(operation);

    // Item decode for the controller.
    always_comb
    begin
        stat.mac   = (op_in == OP_MAC);
        stat.quick = !((op_in inside {OP_ENC, OP_DEC, OP_CTR_START, OP_MAC}) ||
                       (op_in == OP_CTR_BLOCK && byte_count != '0));
    end

    // Counter step: low word mod 2^32, high word mod 2^32-1 (end-around carry).
    assign ctr_lo       = counter_reg[WORD_W-1:0] + CTR_ADD_LOW;
    assign ctr_hi_sum   = {1'b0, counter_reg[BLK_W-1:WORD_W]} + {1'b0, CTR_ADD_HIGH};
    assign ctr_hi       = ctr_hi_sum[WORD_W-1:0] + WORD_W'(ctr_hi_sum[WORD_W]);
    assign counter_next = {ctr_hi, ctr_lo};

    assign mac_in = (mac_restart ? '0 : mac_reg) ^ data_block;

    // Round: S-box output from the RAMs, rotate, fold into the other half.
    assign new_half = b_reg ^ rotl11(sub_word);

    assign ksel      = key_sel(op_reg, cmd.prime ? '0 : ROUND_W'(cmd.rnd + 1'b1));
    assign kpair     = key_reg[ksel[KSEL_W-1:1]];
    assign key_word  = ksel[0] ? kpair[CFG_W-1:WORD_W] : kpair[WORD_W-1:0];
    assign addr_word = (cmd.prime ? a_reg : new_half) + key_word;
    assign table_we  = cmd.capture && (op_in == OP_LOAD);

    for (genvar k = 0; k < NUM_BOX; k++)
    begin : g_box
        gost_ram #(
            .WIDTH (NIB_W),
            .DEPTH (SBOX_DEPTH)
        ) u_box (
            .clk   (clk),
            .we    (table_we),
            .waddr (table_index),
            .wdata (table_word[NIB_W*k +: NIB_W]),
            .raddr (addr_word[NIB_W*k +: NIB_W]),
            .rdata (sub_word[NIB_W*k +: NIB_W])
        );
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (cmd.capture)
        begin
            case (op_in)
                OP_CTR_BLOCK:
                begin
                    a_next = counter_next[WORD_W-1:0];
                    b_next = counter_next[BLK_W-1:WORD_W];
                end
                OP_MAC:
                begin
                    a_next = mac_in[WORD_W-1:0];
                    b_next = mac_in[BLK_W-1:WORD_W];
                end
                default:
                begin
                    a_next = data_block[WORD_W-1:0];
                    b_next = data_block[BLK_W-1:WORD_W];
                end
            endcase
        end
        else if (cmd.step)
        begin
            a_next = new_half;
            b_next = a_reg;
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_ENC, OP_DEC, OP_CTR_START:
                result_next = {a_reg, b_reg};
            OP_CTR_BLOCK:
                result_next = (data_reg ^ {a_reg, b_reg}) & byte_mask(cnt_reg);
            OP_MAC:
                result_next = {b_reg, a_reg};
            default:
                result_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (cmd.capture)
        begin
            op_reg   <= op_in;
            cnt_reg  <= byte_count;
            data_reg <= data_block;
        end
        if (cmd.finish)
        begin
            result_reg   <= result_next;
            mac_word_reg <= (op_reg == OP_MAC) ? a_reg : mac_reg[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
            counter_reg <= '0;
            mac_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                key_reg[cfg_index] <= cfg_data;
            end
            if (cmd.capture && op_in == OP_CTR_BLOCK && byte_count != '0)
            begin
                counter_reg <= counter_next;
            end
            if (cmd.finish && op_reg == OP_CTR_START)
            begin
                counter_reg <= {a_reg, b_reg};
            end
            if (cmd.finish && op_reg == OP_MAC)
            begin
                mac_reg <= {b_reg, a_reg};
            end
        end
    end

    assign result_block = result_reg;
    assign mac_word     = mac_word_reg;
endmodule

// File: design/gost_block_cipher_modes_unit.sv
// 64-bit block cipher engine with a 256-bit key and a loadable substitution table.
// Input channel in_ch: one transaction per item (load table word, encrypt, decrypt,
// start counter, counter block, MAC block). Output channel out_ch: exactly one
// transaction per item, in order. Key words are written through cfg_wr_en /
// cfg_index / cfg_data, by the user only while no item is in flight; the block
// does not enforce this. Encrypt, decrypt and both counter operations run all
// rounds, a MAC block runs half of them, and a table load, an unused opcode or
// an empty counter block skips them and goes straight to the result write. The
// shared round unit does one round per cycle, fed by the eight 16-entry S-box
// RAMs whose registered read sets the pace: a priming step for the first lookup,
// 32 rounds (16 for the MAC), then the write of the result register. The next
// item is accepted once the control is back in idle after that write.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is accepted and processed, and that item then waits in
// its final step until the register is taken.
// Reset clears the key, counter and MAC registers and the control; the
// substitution table must be loaded before any block is processed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gost_block_cipher_modes_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    gost_in_if.sink                        in_ch,
    gost_out_if.source                     out_ch,
    input  logic                           cfg_wr_en,
    input  logic [gost_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gost_pkg::CFG_W-1:0]     cfg_data
);
    import gost_pkg::*;

    gost_cmd_t  cmd;
    gost_stat_t stat;

    gost_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gost_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (in_ch.operation),
        .table_index  (in_ch.table_index),
        .table_word   (in_ch.table_word),
        .data_block   (in_ch.data_block),
        .byte_count   (in_ch.byte_count),
        .mac_restart  (in_ch.mac_restart),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_block (out_ch.result_block),
        .mac_word     (out_ch.mac_word)
    );

    `GOST_ASSERT_CLK(a_busy_not_ready, (cmd.prime || cmd.step) |-> !in_ch.ready, "ready while rounds run")
    `GOST_ASSERT_CLK(a_accept_blocks, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "back-to-back accept")
    `GOST_ASSERT_CLK(a_finish_shows, cmd.finish |=> out_ch.valid, "result not presented")
    `GOST_ASSERT_NEVER(a_cmd_overlap, (cmd.prime && cmd.step) || (cmd.step && cmd.finish), "overlapping commands")
endmodule

// File: tb/gost_block_cipher_modes_unit_tb.sv
`timescale 1ns / 1ps
module gost_block_cipher_modes_unit_tb;
    import gost_pkg::*;

    localparam logic [CFG_IDX_W-1:0] KEY_W01 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] KEY_W23 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] KEY_W45 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] KEY_W67 = 2'd3;

    // Opcodes the block must ignore.
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [SBOX_AW-1:0] index;
        logic [WORD_W-1:0]  word;
        logic [BLK_W-1:0]   data;
        logic [CNT_W-1:0]   count;
        logic               restart;
    } gost_item_t;

    typedef struct {
        logic [BLK_W-1:0]  block;
        logic [WORD_W-1:0] mac;
    } gost_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gost_in_if  in_ch ();
    gost_out_if out_ch ();

    gost_block_cipher_modes_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Engine state as the testbench sees it.
    logic [CFG_W-1:0]  key_copy  [KEY_REGS] = '{default: '0};
    logic [WORD_W-1:0] sbox_copy [SBOX_DEPTH];
    logic [BLK_W-1:0]  ctr_reg = '0;
    logic [BLK_W-1:0]  mac_reg = '0;

    gost_item_t   queued_items [$];
    gost_result_t due_outputs  [$];
    gost_item_t   on_wire;
    gost_result_t want;

    int src_max   = 5;
    int sink_max  = 5;
    int src_wait  = 0;
    int sink_wait = 0;
    int sink_draw;
    int err_count = 0;
    int cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] key_word_of(input int unsigned n);
        return n[0] ? key_copy[n >> 1][63:32] : key_copy[n >> 1][31:0];
    endfunction

    function automatic logic [WORD_W-1:0] sbox_round(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = '0;
        for (int k = 0; k < NUM_BOX; k++)
            y[NIB_W*k +: NIB_W] = sbox_copy[x[NIB_W*k +: NIB_W]][NIB_W*k +: NIB_W];
        return {y[WORD_W-ROT_AMT-1:0], y[WORD_W-1:WORD_W-ROT_AMT]};
    endfunction

    // Run n rounds with a = low word, b = high word; return {b, a}.
    function automatic logic [BLK_W-1:0] run_rounds(input logic [BLK_W-1:0] blk,
                                                    input int n, input logic decrypt);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        int unsigned       ki;
        a = blk[31:0];
        b = blk[63:32];
        for (int r = 0; r < n; r++)
        begin
            // decrypt walks the key backward after the first eight rounds,
            // encrypt only in the last eight
            if (decrypt ? (r >= 8) : (r >= 24))
                ki = 7 - (r % 8);
            else
                ki = r % 8;
            if (r % 2 == 0)
                b = b ^ sbox_round(a + key_word_of(ki));
            else
                a = a ^ sbox_round(b + key_word_of(ki));
        end
        return {b, a};
    endfunction

    function automatic logic [BLK_W-1:0] ecb_block(input logic [BLK_W-1:0] blk,
                                                   input logic decrypt);
        logic [BLK_W-1:0] r;
        r = run_rounds(blk, 32, decrypt);
        return {r[31:0], r[63:32]};
    endfunction

    function automatic gost_result_t step_engine(input gost_item_t it);
        gost_result_t      res;
        logic [CNT_W-1:0]  nb;
        logic [BLK_W-1:0]  keep;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        res.block = '0;
        case (it.op)
            OP_LOAD:
                sbox_copy[it.index] = it.word;
            OP_ENC:
                res.block = ecb_block(it.data, 1'b0);
            OP_DEC:
                res.block = ecb_block(it.data, 1'b1);
            OP_CTR_START:
            begin
                ctr_reg   = ecb_block(it.data, 1'b0);
                res.block = ctr_reg;
            end
            OP_CTR_BLOCK:
            begin
                if (it.count != 0)
                begin
                    lo = ctr_reg[31:0] + CTR_ADD_LOW;
                    hi = ctr_reg[63:32] + CTR_ADD_HIGH;
                    // high word counts modulo 2^32-1: fold the carry back in
                    if (hi < CTR_ADD_HIGH)
                        hi = hi + 1'b1;
                    ctr_reg = {hi, lo};
                    nb = (it.count > FULL_BYTES) ? FULL_BYTES : it.count;
                    keep = (nb == FULL_BYTES) ? '1 : ((64'd1 << (8 * nb)) - 1);
                    res.block = (it.data ^ ecb_block(ctr_reg, 1'b0)) & keep;
                end
            end
            OP_MAC:
            begin
                if (it.restart)
                    mac_reg = '0;
                mac_reg   = run_rounds(mac_reg ^ it.data, 16, 1'b0);
                res.block = mac_reg;
            end
            default:
                ;
        endcase
        res.mac = mac_reg[31:0];
        return res;
    endfunction

    // Item with every field random; callers pin down what matters.
    function automatic gost_item_t any_item(input logic [OP_W-1:0] op);
        gost_item_t it;
        it.op      = op;
        it.index   = SBOX_AW'($urandom_range(0, SBOX_DEPTH - 1));
        it.word    = $urandom;
        it.data    = {$urandom, $urandom};
        it.count   = CNT_W'($urandom_range(0, 15));
        it.restart = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Input side: hold each transaction until taken, then wait the drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            src_wait    <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                due_outputs.push_back(step_engine(on_wire));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (src_wait != 0)
                begin
                    in_ch.valid <= 1'b0;
                    src_wait    <= src_wait - 1;
                end
                else if (queued_items.size() != 0)
                begin
                    on_wire = queued_items.pop_front();
                    in_ch.operation   <= on_wire.op;
                    in_ch.table_index <= on_wire.index;
                    in_ch.table_word  <= on_wire.word;
                    in_ch.data_block  <= on_wire.data;
                    in_ch.byte_count  <= on_wire.count;
                    in_ch.mac_restart <= on_wire.restart;
                    in_ch.valid       <= 1'b1;
                    src_wait          <= $urandom_range(0, src_max);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Output side: check each transaction, then stall for the drawn count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_wait    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_outputs.size() == 0)
                begin
                    err_count = err_count + 1;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result_block %h mac_word %h", $realtime,
                                 out_ch.result_block, out_ch.mac_word);
                end
                else
                begin
                    want = due_outputs.pop_front();
                    if (out_ch.result_block !== want.block || out_ch.mac_word !== want.mac)
                    begin
                        err_count = err_count + 1;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: mismatch result_block exp %h got %h, mac_word exp %h got %h",
                                     $realtime, want.block, out_ch.result_block,
                                     want.mac, out_ch.mac_word);
                    end
                end
                sink_draw = $urandom_range(0, sink_max);
                out_ch.ready <= (sink_draw == 0);
                sink_wait    <= sink_draw;
            end
            else if (!out_ch.ready)
            begin
                if (sink_wait <= 1)
                    out_ch.ready <= 1'b1;
                if (sink_wait != 0)
                    sink_wait <= sink_wait - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** gost_block_cipher_modes_unit: FAILED **");
            $finish;
        end
    end

    // Sample at the falling edge so the driver's updates have settled.
    task automatic wait_idle();
        while (queued_items.size() != 0 || in_ch.valid || due_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en     <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= value;
        key_copy[idx] = value;
    endtask

    task automatic set_keys(input logic [CFG_W-1:0] k01, input logic [CFG_W-1:0] k23,
                            input logic [CFG_W-1:0] k45, input logic [CFG_W-1:0] k67);
        write_key(KEY_W01, k01);
        write_key(KEY_W23, k23);
        write_key(KEY_W45, k45);
        write_key(KEY_W67, k67);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed counter runs and MAC chains, with ECB and noise mixed in.
    task automatic queue_random(input int n);
        gost_item_t it;
        int         added;
        int         len;
        int         pick;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                queued_items.push_back(any_item(OP_CTR_START));
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    it = any_item(OP_CTR_BLOCK);
                    it.count = (i == len - 1) ? CNT_W'($urandom_range(1, 8)) : FULL_BYTES;
                    queued_items.push_back(it);
                end
                added += len + 1;
            end
            else if (pick < 65)
            begin
                len = $urandom_range(2, 6);
                for (int i = 0; i < len; i++)
                begin
                    it = any_item(OP_MAC);
                    it.restart = (i == 0);
                    // zero-pad the tail block
                    if (i == len - 1)
                        it.data = it.data & ({BLK_W{1'b1}} >> (8 * $urandom_range(0, 7)));
                    queued_items.push_back(it);
                end
                added += len;
            end
            else if (pick < 85)
            begin
                queued_items.push_back(any_item($urandom_range(0, 1) ? OP_ENC : OP_DEC));
                added += 1;
            end
            else
            begin
                queued_items.push_back(any_item(OP_W'($urandom_range(OP_LOAD, OP_RSVD_B))));
                added += 1;
            end
        end
    endtask

    initial
    begin
        gost_item_t it;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = '0;
        in_ch.table_index = '0;
        in_ch.table_word  = '0;
        in_ch.data_block  = '0;
        in_ch.byte_count  = '0;
        in_ch.mac_restart = 1'b0;
        out_ch.ready      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_keys('0, '0, '0, '0);

        // fill the whole table before any block goes through
        for (int i = 0; i < SBOX_DEPTH; i++)
        begin
            it = any_item(OP_LOAD);
            it.index = SBOX_AW'(i);
            if (i == 0)
                it.word = '0;
            else if (i == SBOX_DEPTH - 1)
                it.word = '1;
            queued_items.push_back(it);
        end
        it = any_item(OP_ENC);
        it.data = '0;
        queued_items.push_back(it);
        it = any_item(OP_ENC);
        it.data = '1;
        queued_items.push_back(it);
        it = any_item(OP_DEC);
        it.data = '1;
        queued_items.push_back(it);
        queued_items.push_back(any_item(OP_DEC));
        wait_idle();

        // pick the sync so the counter lands just below the high-word wrap
        it = any_item(OP_CTR_START);
        it.data = ecb_block({32'hFEFE_FEFB, 32'hFEFE_FEFF}, 1'b1);
        queued_items.push_back(it);
        it = any_item(OP_CTR_BLOCK);
        it.data  = '1;
        it.count = FULL_BYTES;
        queued_items.push_back(it);
        it = any_item(OP_CTR_BLOCK);
        it.count = CNT_W'(1);
        queued_items.push_back(it);
        it = any_item(OP_CTR_BLOCK);
        it.count = CNT_W'(0);
        queued_items.push_back(it);
        it = any_item(OP_CTR_BLOCK);
        it.count = CNT_W'(15);
        queued_items.push_back(it);
        it = any_item(OP_CTR_BLOCK);
        it.count = CNT_W'(9);
        queued_items.push_back(it);
        it = any_item(OP_MAC);
        it.data    = '1;
        it.restart = 1'b1;
        queued_items.push_back(it);
        it = any_item(OP_MAC);
        it.data    = '0;
        it.restart = 1'b0;
        queued_items.push_back(it);
        it = any_item(OP_MAC);
        it.data    = it.data & 64'h0000_00FF_FFFF_FFFF;
        it.restart = 1'b1;
        queued_items.push_back(it);
        queued_items.push_back(any_item(OP_RSVD_A));
        queued_items.push_back(any_item(OP_RSVD_B));
        wait_idle();

        // back to back on both sides
        src_max  = 0;
        sink_max = 0;
        set_keys('1, '1, '1, '1);
        queue_random(150);
        wait_idle();

        src_max  = 5;
        sink_max = 5;
        set_keys({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        queue_random(150);
        wait_idle();

        src_max  = 5;
        sink_max = 0;
        set_keys({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        queue_random(150);
        wait_idle();

        src_max  = 0;
        sink_max = 5;
        set_keys(64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA,
                 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
        queue_random(150);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && due_outputs.size() == 0)
            $display("** gost_block_cipher_modes_unit: PASSED **");
        else
            $display("** gost_block_cipher_modes_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/gost_pkg.sv
design/gost_if.sv
design/gost_ram.sv
design/gost_ctrl.sv
design/gost_dpath.sv
design/gost_block_cipher_modes_unit.sv
tb/gost_block_cipher_modes_unit_tb.sv
